>>> rtl/vbmt_pkg.sv
// ----------------------------------------------------------------------------
// vbmt_pkg
// Shared types and constants for the vertex batch memo table.
// ----------------------------------------------------------------------------
package vbmt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 32;
    localparam int LEN_W         = 16;
    localparam int VTX_W         = 32;

    typedef enum logic [1:0] {
        OUT_IGNORED   = 2'd0,
        OUT_HIT       = 2'd1,
        OUT_MISS_REM  = 2'd2,
        OUT_MISS_FULL = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] batch_address;
        logic [LEN_W-1:0]  vertex_count;
    } t_req;

    typedef struct packed {
        t_outcome          outcome;
        logic [VTX_W-1:0]  start_vertex;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [VTX_W-1:0]  start;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_tbl_rd;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_tbl_wr;

endpackage

>>> rtl/vbmt_table.sv
// ----------------------------------------------------------------------------
// vbmt_table
// Entry store with one registered read port, one write port, and a
// compare of the read entry against the search key.
// ----------------------------------------------------------------------------
module vbmt_table
    import vbmt_pkg::*;
(
    input  logic             i_clk,
    input  t_tbl_rd          i_rd,
    input  t_tbl_wr          i_wr,
    input  t_req             i_key,
    output logic             o_match,
    output logic [VTX_W-1:0] o_start
);

    t_entry mem [TABLE_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.idx];
        end
    end

    assign o_match = (r_rd_data.address == i_key.batch_address) &&
                     (r_rd_data.length == i_key.vertex_count);
    assign o_start = r_rd_data.start;

endmodule

>>> rtl/vertex_batch_memo_table.sv
// ----------------------------------------------------------------------------
// vertex_batch_memo_table
// Remembers converted vertex batches by address and count; returns the
// stored start vertex on a hit, or the running vertex counter on a miss.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                 | payload
//  request   | in  | i_req_valid / o_req_stall | i_req (t_req)
//  response  | out | o_rsp_valid / i_rsp_stall | o_rsp (t_rsp)
//
//  One request at a time. An ignored request skips the scan and goes straight
//  to response. Lookup stops at the first hit or after all used entries; one
//  entry read per cycle from the table's single read port is the limit.
//  Synchronous active-low reset clears the counters; the table needs no clear.
//  A waiting response does not block the next request; a stalled output
//  holds the finished result until the register frees.
// ----------------------------------------------------------------------------
module vertex_batch_memo_table
    import vbmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    t_state             r_state, n_state;
    t_req               r_key, n_key;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [VTX_W-1:0]   r_total, n_total;
    t_rsp               r_res, n_res;
    logic               r_out_vld, n_out_vld;
    t_rsp               r_out, n_out;

    t_tbl_rd            tbl_rd;
    t_tbl_wr            tbl_wr;
    logic               tbl_match;
    logic [VTX_W-1:0]   tbl_start;

    logic w_accept, w_ignore, w_issue, w_hit, w_miss, w_out_free;

    vbmt_table u_table (
        .i_clk   (i_clk),
        .i_rd    (tbl_rd),
        .i_wr    (tbl_wr),
        .i_key   (r_key),
        .o_match (tbl_match),
        .o_start (tbl_start)
    );

    assign w_accept   = i_req_valid && (r_state == ST_IDLE);
    assign w_ignore   = (i_req.batch_address == '0) || (i_req.vertex_count == '0);
    assign w_issue    = (r_idx < r_used);
    assign w_hit      = (r_state == ST_SCAN) && r_pend && tbl_match;
    assign w_miss     = (r_state == ST_SCAN) && !w_issue && !(r_pend && tbl_match);
    assign w_out_free = !r_out_vld || !i_rsp_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_ignore ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_hit || w_miss) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_key     = r_key;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_used    = r_used;
        n_total   = r_total;
        n_res     = r_res;
        n_out_vld = r_out_vld && i_rsp_stall;
        n_out     = r_out;
        tbl_rd    = '0;
        tbl_wr    = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_key  = i_req;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    if (w_ignore) begin
                        n_res.outcome      = OUT_IGNORED;
                        n_res.start_vertex = '0;
                    end
                end
            end
            ST_SCAN: begin
                tbl_rd.en  = w_issue && !w_hit;
                tbl_rd.idx = r_idx[IDX_W-1:0];
                n_pend     = tbl_rd.en;
                if (tbl_rd.en) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (w_hit) begin
                    n_res.outcome      = OUT_HIT;
                    n_res.start_vertex = tbl_start;
                end else if (w_miss) begin
                    n_total            = r_total + VTX_W'(r_key.vertex_count);
                    n_res.start_vertex = r_total;
                    if (r_used < CNT_W'(TABLE_ENTRIES)) begin
                        tbl_wr.en            = 1'b1;
                        tbl_wr.idx           = r_used[IDX_W-1:0];
                        tbl_wr.entry.address = r_key.batch_address;
                        tbl_wr.entry.length  = r_key.vertex_count;
                        tbl_wr.entry.start   = r_total;
                        n_used               = r_used + CNT_W'(1);
                        n_res.outcome        = OUT_MISS_REM;
                    end else begin
                        n_res.outcome = OUT_MISS_FULL;
                    end
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_used    <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_used    <= n_used;
            r_total   <= n_total;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_req_stall = (r_state != ST_IDLE);
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_rd.en |-> (r_idx < r_used))
        else $error("read of an entry never written");

    a_write_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_wr.en |-> (w_miss && !w_hit))
        else $error("table write outside a miss");

    a_total_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_total) |-> $past(w_miss))
        else $error("vertex counter moved without a miss");

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vertex_batch_memo_table. Requests are sent through
// the valid/stall channel while an in-bench copy of the memo table computes
// the expected outcome and start vertex for each one. Responses are checked
// in order against that copy. It covers ignored requests, hits, near misses,
// filling the table, misses on a full table, and long response back-pressure,
// with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module testbench
    import vbmt_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req_data  = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    t_rsp rsp_data;

    logic rsp_hold  = 1'b0;
    logic hold_kick = 1'b0;
    int   hold_cycles;
    int   rsp_wait_left = 0;
    bit   idle_on = 1'b0;
    int   mismatch_count = 0;

    // in-bench copy of the memo table
    logic [ADDR_W-1:0] memo_addr  [TABLE_ENTRIES];
    logic [LEN_W-1:0]  memo_len   [TABLE_ENTRIES];
    logic [VTX_W-1:0]  memo_start [TABLE_ENTRIES];
    int                memo_used = 0;
    logic [VTX_W-1:0]  next_vertex = '0;

    t_rsp pending_rsp [$];
    t_req sent_batches [$];

    vertex_batch_memo_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req_data),
        .o_rsp_valid (rsp_valid),
        .i_rsp_stall (rsp_stall),
        .o_rsp       (rsp_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_rsp lookup_batch(input t_req req);
        t_rsp rsp;
        rsp.outcome      = OUT_IGNORED;
        rsp.start_vertex = '0;
        if (req.batch_address == '0 || req.vertex_count == '0) begin
            return rsp;
        end
        for (int i = 0; i < memo_used; i++) begin
            if (memo_addr[i] == req.batch_address && memo_len[i] == req.vertex_count) begin
                rsp.outcome      = OUT_HIT;
                rsp.start_vertex = memo_start[i];
                return rsp;
            end
        end
        rsp.start_vertex = next_vertex;
        next_vertex      = next_vertex + VTX_W'(req.vertex_count);
        if (memo_used < TABLE_ENTRIES) begin
            memo_addr[memo_used]  = req.batch_address;
            memo_len[memo_used]   = req.vertex_count;
            memo_start[memo_used] = rsp.start_vertex;
            memo_used++;
            rsp.outcome = OUT_MISS_REM;
        end else begin
            rsp.outcome = OUT_MISS_FULL;
        end
        if (sent_batches.size() >= 256) begin
            void'(sent_batches.pop_front());
        end
        sent_batches.push_back(req);
        return rsp;
    endfunction

    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic [LEN_W-1:0] cnt);
        int   gap;
        t_req req;
        gap               = idle_on ? $urandom_range(0, 15) : 0;
        req.batch_address = addr;
        req.vertex_count  = cnt;
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        pending_rsp.push_back(lookup_batch(req));
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 4) @(posedge i_clk);
    endtask

    task automatic send_random_request();
        int                r;
        int                k;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  cnt;
        r    = $urandom_range(0, 99);
        addr = $urandom;
        cnt  = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(1, 16))
                                           : LEN_W'($urandom_range(1, 65535));
        if (r < 8) begin
            case ($urandom_range(0, 2))
                0: addr = '0;
                1: cnt  = '0;
                default: begin
                    addr = '0;
                    cnt  = '0;
                end
            endcase
        end else if (r < 45 && memo_used > 0) begin
            k    = $urandom_range(0, memo_used - 1);
            addr = memo_addr[k];
            cnt  = memo_len[k];
        end else if (r < 55 && sent_batches.size() > 0) begin
            k    = $urandom_range(0, sent_batches.size() - 1);
            addr = sent_batches[k].batch_address;
            cnt  = sent_batches[k].vertex_count;
        end else if (r < 65 && memo_used > 0) begin
            // near miss: one bit off in address or count
            k    = $urandom_range(0, memo_used - 1);
            addr = memo_addr[k];
            cnt  = memo_len[k];
            if ($urandom_range(0, 1) == 0) begin
                addr[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
            end else begin
                cnt[$urandom_range(0, LEN_W - 1)] ^= 1'b1;
            end
        end
        send_request(addr, cnt);
    endtask

    task automatic run_random_requests(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_random_request();
        end
        drain_responses();
    endtask

    task automatic test_ignored_requests();
        idle_on = 1'b1;
        send_request(32'h0000_0000, 16'h0005);
        send_request(32'h0000_1234, 16'h0000);
        send_request(32'h0000_0000, 16'h0000);
        send_request(32'hFFFF_FFFF, 16'h0000);
        send_request(32'h0000_0000, 16'hFFFF);
        drain_responses();
    endtask

    task automatic test_miss_and_hit();
        idle_on = 1'b0;
        send_request(32'hFFFF_FFFF, 16'hFFFF);
        send_request(32'hFFFF_FFFF, 16'hFFFF);
        send_request(32'hFFFF_FFFF, 16'hFFFE);
        send_request(32'hFFFF_FFFE, 16'hFFFF);
        send_request(32'h0000_0001, 16'h0001);
        send_request(32'h0000_0001, 16'h0001);
        send_request(32'h0000_0000, 16'h0001);
        send_request(32'h8000_0000, 16'h8000);
        send_request(32'hFFFF_FFFF, 16'hFFFF);
        send_request(32'h8000_0000, 16'h8000);
        send_request(32'h0000_0001, 16'h0002);
        drain_responses();
    endtask

    task automatic test_random_filling();
        run_random_requests(250);
    endtask

    task automatic test_table_full();
        idle_on = 1'b1;
        while (memo_used < TABLE_ENTRIES) begin
            send_request({$urandom_range(1, 32'h7FFF_FFFF)}, LEN_W'($urandom_range(1, 65535)));
        end
        send_request(32'hDEAD_0000, 16'h0010);
        send_request(32'hDEAD_0000, 16'h0010);
        send_request(memo_addr[TABLE_ENTRIES - 1], memo_len[TABLE_ENTRIES - 1]);
        send_request(memo_addr[0], memo_len[0]);
        send_request(32'h0000_0000, 16'h0010);
        send_request(32'hFFFF_FFFF, 16'hFFFF);
        drain_responses();
    endtask

    task automatic test_backpressure();
        idle_on     = 1'b0;
        hold_cycles = 400;
        hold_kick   = 1'b1;
        for (int i = 0; i < 10; i++) begin
            send_random_request();
        end
        drain_responses();
    endtask

    task automatic test_random_full();
        run_random_requests(420);
    endtask

    // long response hold-off
    initial begin
        wait (hold_kick);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (hold_cycles) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    // per-response stall draw
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            rsp_stall     <= 1'b0;
            rsp_wait_left <= 0;
        end else if (rsp_hold) begin
            rsp_stall <= 1'b1;
        end else if (rsp_wait_left != 0) begin
            rsp_stall     <= 1'b1;
            rsp_wait_left <= rsp_wait_left - 1;
        end else if (rsp_valid && !rsp_stall) begin
            n = idle_on ? $urandom_range(0, 15) : 0;
            rsp_stall     <= (n != 0);
            rsp_wait_left <= (n != 0) ? n - 1 : 0;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual outcome %0d start %0d",
                         $time, rsp_data.outcome, rsp_data.start_vertex);
                mismatch_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_data.outcome !== want.outcome) begin
                    $display("%0t: outcome mismatch, expected %0d, actual %0d",
                             $time, want.outcome, rsp_data.outcome);
                    mismatch_count++;
                end
                if (rsp_data.start_vertex !== want.start_vertex) begin
                    $display("%0t: start_vertex mismatch, expected %0d, actual %0d",
                             $time, want.start_vertex, rsp_data.start_vertex);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ignored_requests();
        test_miss_and_hit();
        test_random_filling();
        test_table_full();
        test_backpressure();
        test_random_full();
        if (pending_rsp.size() != 0) begin
            $display("%0t: %0d responses missing", $time, pending_rsp.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> vertex_batch_memo_table.f
rtl/vbmt_pkg.sv
rtl/vbmt_table.sv
rtl/vertex_batch_memo_table.sv
tb/sv/testbench.sv
